### rtl/atsid_pkg.sv
// Package for the array table search, insert and delete unit.
// Holds the table size, the derived widths, the request and status codes and the result type.
// Depends on nothing; every module of the unit imports it.
package atsid_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((VALUE_W + IDX_W + 7) / 8) * 8;
    localparam int RES_W     = STATUS_W + IDX_W + 1 + IDX_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_APPEND         = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIND           = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE_AT      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT_AT      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SORTED_INSERT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FIND_OR_INSERT = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0] count;
        logic             found;
        logic [IDX_W-1:0] index;
        status_t          status;
    } result_t;

endpackage

### rtl/atsid_obuf.sv
// Output register of the array table unit: one result held for the master-side stream.
// Depends on atsid_pkg for the result type and the tdata width.
module atsid_obuf
    import atsid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  result_t              push_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, index, found, count from bit 0 up, zero padded
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign push_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_tdata    = M_TDATA_W'(data_reg);

    always_comb begin
        valid_next = valid_reg;
        if (push_valid && push_ready) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid && push_ready) begin
            data_reg <= push_data;
        end
    end

endmodule

### rtl/array_table_search_insert_delete_unit.sv
// Top level of the array table unit: a table of signed words in one synchronous memory.
// Depends on atsid_pkg and on atsid_obuf for the result register.
//
// A request arrives on the slave-side stream: tuser carries the operation code and tdata
// the value and the position. Each accepted transfer gives exactly one result transfer on
// the master-side stream with a status, an index, a found flag and the new fill count.
// The table sits in a memory with one write and one registered read port, and each walk
// over it moves one entry per cycle. An append, a refused request and an unused code go
// straight to the result. A find walks the table until it meets the value or the end.
// A delete at p shifts the entries above p down one place, and an insert at p shifts the
// entries from p up one place and writes the value at p. A sorted insert walks to the
// first entry greater than the value and then inserts there in the same way. A find or
// insert that misses walks the table again as a sorted insert does and inserts there, or
// reports a full table if no entry is free.
// One request is worked on at a time; s_tready is high while the unit is waiting,
// from the cycle after the result has been loaded.
// A finished result waits in the output register, so a new request is taken while the
// receiver stalls, and that request's result waits until the register is free.
// Reset empties the table at once; the memory contents are not cleared.
module array_table_search_insert_delete_unit
    import atsid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // value, position from bit 0 up, zero padded
    input  logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, index, found, count from bit 0 up, zero padded
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_SHUP = 6'b000100,
        S_SHDN = 6'b001000,
        S_DONE = 6'b010000,
        S_HOLD = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [KIND_W-1:0]          kind_reg, kind_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           count_reg, count_next;
    logic                       sorted_reg, sorted_next;
    result_t                    res_reg, res_next;

    logic [VALUE_W-1:0]         mem [CAPACITY];
    logic [VALUE_W-1:0]         rd_data_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [VALUE_W-1:0]         mem_wdata;

    logic                       accept;
    logic                       full;
    logic [VALUE_W-1:0]         in_value;
    logic [IDX_W-1:0]           in_pos;
    logic                       at_end;
    logic                       stop;
    logic                       push_valid;
    logic                       push_ready;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[VALUE_W +: IDX_W];
    assign full     = (count_reg == IDX_W'(CAPACITY));
    assign at_end   = (idx_reg >= count_reg);
    assign stop     = at_end || (sorted_reg ? ($signed(rd_data_reg) > value_reg)
                                            : (rd_data_reg == value_reg));

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        sorted_next = sorted_reg;
        res_next    = res_reg;
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(idx_reg);
        mem_wdata   = rd_data_reg;
        rd_addr     = ADDR_W'(idx_reg + IDX_W'(1));
        push_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                if (accept) begin
                    kind_next   = s_tuser;
                    value_next  = in_value;
                    pos_next    = in_pos;
                    idx_next    = '0;
                    sorted_next = 1'b0;
                    res_next    = '{count: count_reg, found: 1'b0, index: '0, status: ST_OK};
                    state_next  = S_DONE;
                    unique case (s_tuser)
                        KIND_APPEND: begin
                            if (full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                mem_we         = 1'b1;
                                mem_waddr      = ADDR_W'(count_reg);
                                mem_wdata      = in_value;
                                count_next     = count_reg + IDX_W'(1);
                                res_next.index = count_reg;
                            end
                        end
                        KIND_FIND: begin
                            state_next = S_SCAN;
                        end
                        KIND_DELETE_AT: begin
                            if (in_pos >= count_reg) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                idx_next   = in_pos;
                                rd_addr    = ADDR_W'(in_pos + IDX_W'(1));
                                state_next = S_SHDN;
                            end
                        end
                        KIND_INSERT_AT: begin
                            if (full) begin
                                res_next.status = ST_FULL;
                            end else if (in_pos > count_reg) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                idx_next   = count_reg;
                                rd_addr    = ADDR_W'(count_reg - IDX_W'(1));
                                state_next = S_SHUP;
                            end
                        end
                        KIND_SORTED_INSERT: begin
                            if (full) begin
                                res_next.status = ST_FULL;
                            end else begin
                                sorted_next = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        KIND_FIND_OR_INSERT: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                idx_next = idx_reg + IDX_W'(1);
                if (stop) begin
                    priority if (sorted_reg) begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        rd_addr    = ADDR_W'(count_reg - IDX_W'(1));
                        state_next = S_SHUP;
                    end else if (!at_end) begin
                        res_next.index = idx_reg;
                        res_next.found = 1'b1;
                        state_next     = S_DONE;
                    end else if (kind_reg == KIND_FIND) begin
                        res_next.status = ST_NOTFOUND;
                        state_next      = S_DONE;
                    end else if (full) begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end else begin
                        sorted_next = 1'b1;
                        idx_next    = '0;
                        rd_addr     = '0;
                    end
                end
            end
            S_SHUP: begin
                mem_we = 1'b1;
                if (idx_reg == pos_reg) begin
                    mem_waddr      = ADDR_W'(pos_reg);
                    mem_wdata      = value_reg;
                    count_next     = count_reg + IDX_W'(1);
                    res_next.index = pos_reg;
                    state_next     = S_DONE;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                    rd_addr  = ADDR_W'(idx_reg - IDX_W'(2));
                end
            end
            S_SHDN: begin
                if ((idx_reg + IDX_W'(1)) >= count_reg) begin
                    count_next     = count_reg - IDX_W'(1);
                    res_next.index = pos_reg;
                    state_next     = S_DONE;
                end else begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                    rd_addr  = ADDR_W'(idx_reg + IDX_W'(2));
                end
            end
            S_DONE: begin
                state_next = S_HOLD;
            end
            S_HOLD: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (state_next == S_DONE) begin
            res_next.count = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        sorted_reg <= sorted_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    atsid_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (res_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### sim/tb_top.sv
// Self-checking testbench for the array table search, insert and delete unit.
// Drives requests from a queue, predicts every result with its own table and checks each
// result transfer in order. Depends on atsid_pkg and array_table_search_insert_delete_unit.
`timescale 1ns / 1ps

module tb_top;
    import atsid_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int RANDOM_REQS = 1650;
    localparam int PHASE_LEN   = 413;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [IDX_W-1:0]          pos;
        int                        phase;
        bit                        hold;
        bit                        drain;
    } request_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    request_t pending_reqs[$];
    result_t  expected_results[$];

    logic signed [VALUE_W-1:0] table_words [CAPACITY];
    int  table_fill  = 0;
    int  mismatches  = 0;
    int  quiet_count = 0;
    int  hold_left   = 0;
    int  cur_phase   = 0;
    bit  in_fire     = 1'b0;
    bit  hold_start  = 1'b0;
    int  gen_phase   = 0;
    bit  gen_hold    = 1'b0;
    bit  gen_drain   = 1'b0;

    array_table_search_insert_delete_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    task automatic open_slot(input int slot, input logic signed [VALUE_W-1:0] v);
        int i;
        for (i = table_fill; i > slot; i--) begin
            table_words[i] = table_words[i-1];
        end
        table_words[slot] = v;
        table_fill++;
    endtask

    task automatic apply_request(input logic [KIND_W-1:0] k,
                                 input logic signed [VALUE_W-1:0] v,
                                 input logic [IDX_W-1:0] p, output result_t r);
        int  hit;
        int  slot;
        int  i;
        bit  full;
        hit  = 0;
        slot = 0;
        full = (table_fill >= CAPACITY);
        while (hit < table_fill && table_words[hit] != v) hit++;
        while (slot < table_fill && table_words[slot] <= v) slot++;
        r.status = ST_OK;
        r.index  = '0;
        r.found  = 1'b0;
        case (k)
            KIND_APPEND: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    r.index = IDX_W'(table_fill);
                    open_slot(table_fill, v);
                end
            end
            KIND_FIND: begin
                if (hit < table_fill) begin
                    r.index = IDX_W'(hit);
                    r.found = 1'b1;
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            KIND_DELETE_AT: begin
                if (int'(p) >= table_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = int'(p); i + 1 < table_fill; i++) begin
                        table_words[i] = table_words[i+1];
                    end
                    table_fill--;
                    r.index = p;
                end
            end
            KIND_INSERT_AT: begin
                if (full) begin
                    r.status = ST_FULL;
                end else if (int'(p) > table_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    open_slot(int'(p), v);
                    r.index = p;
                end
            end
            KIND_SORTED_INSERT: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    open_slot(slot, v);
                    r.index = IDX_W'(slot);
                end
            end
            KIND_FIND_OR_INSERT: begin
                if (hit < table_fill) begin
                    r.index = IDX_W'(hit);
                    r.found = 1'b1;
                end else if (full) begin
                    r.status = ST_FULL;
                end else begin
                    open_slot(slot, v);
                    r.index = IDX_W'(slot);
                end
            end
            default: begin
            end
        endcase
        r.count = IDX_W'(table_fill);
    endtask

    task automatic add_request(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v,
                               input logic [IDX_W-1:0] p);
        request_t q;
        q.kind  = k;
        q.value = v;
        q.pos   = p;
        q.phase = gen_phase;
        q.hold  = gen_hold;
        q.drain = gen_drain;
        pending_reqs.push_back(q);
        gen_hold  = 1'b0;
        gen_drain = 1'b0;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50) begin
            return VALUE_W'($signed($urandom_range(16)) - 8);
        end else if (r < 60) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [IDX_W-1:0] pick_position();
        if ($urandom_range(9) == 0) begin
            return IDX_W'($urandom_range(127));
        end
        return IDX_W'($urandom_range(70));
    endfunction

    // Requests are offered at the falling edge; in_fire tells whether the last one was taken.
    always @(negedge aclk) begin : driver
        logic     nv;
        bit       hs;
        request_t it;
        nv = s_tvalid;
        hs = 1'b0;
        if (aresetn && !(s_tvalid && !in_fire)) begin
            nv = 1'b0;
            if (pending_reqs.size() != 0 &&
                    !(pending_reqs[0].drain && expected_results.size() != 0) &&
                    $urandom_range(99) >= ((pending_reqs[0].phase == 1) ? 77 :
                                           (pending_reqs[0].phase == 3) ? 27 : 0)) begin
                it = pending_reqs.pop_front();
                s_tdata   <= {{(S_TDATA_W - VALUE_W - IDX_W){1'b0}}, it.pos, it.value};
                s_tuser   <= it.kind;
                cur_phase <= it.phase;
                nv = 1'b1;
                hs = it.hold;
            end
        end
        s_tvalid   <= nv;
        hold_start <= hs;
    end

    always @(negedge aclk) begin : receiver
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        m_tready <= aresetn && !hold_start && hold_left == 0 &&
                    $urandom_range(99) >= ((cur_phase == 2) ? 77 : (cur_phase == 3) ? 27 : 0);
    end

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (expected_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: status %0d index %0d found %0d count %0d",
                             got.status, got.index, got.found, got.count);
                end
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.index !== want.index ||
                        got.found !== want.found || got.count !== want.count) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected status %0d index %0d found %0d count %0d",
                                 want.status, want.index, want.found, want.count);
                        $display("          got status %0d index %0d found %0d count %0d",
                                 got.status, got.index, got.found, got.count);
                    end
                    mismatches++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            apply_request(s_tuser, s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: IDX_W], want);
            expected_results.push_back(want);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            quiet_count++;
        end else begin
            quiet_count = 0;
        end
        if (quiet_count >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int               i;
        int               r;
        int               mood;
        logic [KIND_W-1:0] k;
        mood = 0;

        add_request(KIND_FIND, 32'sd0, 7'd0);
        add_request(KIND_DELETE_AT, 32'sd0, 7'd0);
        add_request(KIND_INSERT_AT, 32'sd9, 7'd1);
        add_request(KIND_INSERT_AT, 32'sd0, 7'd0);
        add_request(KIND_APPEND, 32'sh7fff_ffff, 7'd0);
        add_request(KIND_APPEND, 32'sh8000_0000, 7'd127);
        add_request(KIND_APPEND, -32'sd1, 7'd0);
        add_request(KIND_SORTED_INSERT, 32'sd5, 7'd0);
        add_request(KIND_SORTED_INSERT, -32'sd1, 7'd0);
        add_request(KIND_FIND, -32'sd1, 7'd0);
        add_request(KIND_FIND, 32'sd12345, 7'd0);
        add_request(KIND_FIND, 32'sh8000_0000, 7'd0);
        add_request(KIND_FIND_OR_INSERT, -32'sd1, 7'd0);
        add_request(KIND_FIND_OR_INSERT, 32'sd7, 7'd0);
        add_request(KIND_INSERT_AT, 32'sh5555_aaaa, 7'd7);
        add_request(KIND_INSERT_AT, 32'sh0f0f_0f0f, 7'd127);
        add_request(KIND_INSERT_AT, 32'sh0f0f_0f0f, 7'd64);
        add_request(KIND_DELETE_AT, 32'sd0, 7'd127);
        add_request(KIND_DELETE_AT, 32'sd0, 7'd64);
        add_request(KIND_DELETE_AT, 32'sd0, 7'd0);
        add_request(KIND_DELETE_AT, 32'sd0, 7'd7);
        add_request(KIND_DELETE_AT, 32'sd0, 7'd6);
        add_request(KIND_SPARE_LO, 32'shffff_ffff, 7'd127);
        add_request(KIND_SPARE_HI, 32'sd3, 7'd2);

        for (i = 0; i < RANDOM_REQS; i++) begin
            if (i % PHASE_LEN == 0) begin
                gen_phase = i / PHASE_LEN;
                gen_drain = 1'b1;
            end
            if (i % 150 == 75) gen_drain = 1'b1;
            if (i == 100 || i == 1300) gen_hold = 1'b1;
            if (i % 40 == 0) mood = $urandom_range(2);
            r = $urandom_range(99);
            if (mood == 0) begin
                k = (r < 25) ? KIND_APPEND : (r < 45) ? KIND_SORTED_INSERT :
                    (r < 62) ? KIND_FIND_OR_INSERT : (r < 78) ? KIND_INSERT_AT :
                    (r < 90) ? KIND_FIND : (r < 98) ? KIND_DELETE_AT :
                    (r[0] ? KIND_SPARE_HI : KIND_SPARE_LO);
            end else if (mood == 1) begin
                k = (r < 55) ? KIND_DELETE_AT : (r < 75) ? KIND_FIND :
                    (r < 83) ? KIND_FIND_OR_INSERT : (r < 90) ? KIND_APPEND :
                    (r < 98) ? KIND_INSERT_AT : (r[0] ? KIND_SPARE_HI : KIND_SPARE_LO);
            end else begin
                k = (r < 17) ? KIND_APPEND : (r < 34) ? KIND_FIND :
                    (r < 51) ? KIND_DELETE_AT : (r < 67) ? KIND_INSERT_AT :
                    (r < 83) ? KIND_SORTED_INSERT : (r < 98) ? KIND_FIND_OR_INSERT :
                    (r[0] ? KIND_SPARE_HI : KIND_SPARE_LO);
            end
            add_request(k, pick_value(), pick_position());
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
